[rtl/mmpv_pkg.sv]
// shared types and constants for the modular matrix power vector block
// no dependencies
package mmpv_pkg;

  localparam int VALUE_W = 31;
  localparam int EXP_W   = 63;
  localparam int INDEX_W = 4;
  localparam int DIM_W   = 5;

  localparam logic [VALUE_W-1:0] RESET_MODULUS = 31'd1000000007;
  localparam logic [DIM_W-1:0]   RESET_DIM     = 5'd5;

  // register indexes on the config port
  localparam logic [7:0] REG_MODULUS = 8'd0;
  localparam logic [7:0] REG_DIM     = 8'd1;

  // item kinds
  localparam logic [1:0] ACT_MATRIX = 2'd0;
  localparam logic [1:0] ACT_VECTOR = 2'd1;
  localparam logic [1:0] ACT_RUN    = 2'd2;

  // multiplier a-operand source
  localparam logic [1:0] ASEL_BASE  = 2'd0;
  localparam logic [1:0] ASEL_POWER = 2'd1;
  localparam logic [1:0] ASEL_VEC   = 2'd2;

  typedef struct packed {
    logic               ld_base;
    logic               ld_vec;
    logic               p_init;
    logic               p_init_one;
    logic               p_copy;
    logic               q_we;
    logic               mul_start;
    logic               acc_clear;
    logic [1:0]         a_sel;
    logic               b_row;
    logic               out_load;
    logic               out_last;
    logic [INDEX_W-1:0] out_index;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic out_busy;
  } status_t;

endpackage

[rtl/mmpv_ram.sv]
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module mmpv_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/mmpv_mulmod.sv]
// bit-serial modular multiply-accumulate: (acc + a*b) mod m, b and acc below m
// depends on mmpv_pkg
module mmpv_mulmod (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [mmpv_pkg::VALUE_W-1:0] a,
  input  logic [mmpv_pkg::VALUE_W-1:0] b,
  input  logic [mmpv_pkg::VALUE_W-1:0] acc,
  input  logic [mmpv_pkg::VALUE_W-1:0] m,
  output logic                   done,
  output logic [mmpv_pkg::VALUE_W-1:0] result
);
  import mmpv_pkg::*;

  localparam int CNT_W = $clog2(VALUE_W + 1);

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [VALUE_W-1:0] areg, breg, accreg;
  logic [VALUE_W:0]   dbl, dbl_red, sum, sum_red, fin;

  // one step: r = 2r + abit*b, each half kept below m
  always_comb begin
    dbl     = {result, 1'b0};
    dbl_red = (dbl >= {1'b0, m}) ? dbl - {1'b0, m} : dbl;
    sum     = dbl_red + (areg[VALUE_W-1] ? {1'b0, breg} : '0);
    sum_red = (sum >= {1'b0, m}) ? sum - {1'b0, m} : sum;
    fin     = {1'b0, result} + {1'b0, accreg};
    fin     = (fin >= {1'b0, m}) ? fin - {1'b0, m} : fin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        cnt    <= '0;
        areg   <= a;
        breg   <= b;
        accreg <= acc;
        result <= '0;
      end else if (busy) begin
        if (cnt == CNT_W'(VALUE_W)) begin
          result <= fin[VALUE_W-1:0];
          busy   <= 1'b0;
          done   <= 1'b1;
        end else begin
          result <= sum_red[VALUE_W-1:0];
          areg   <= {areg[VALUE_W-2:0], 1'b0};
          cnt    <= cnt + 1'b1;
        end
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("mulmod done held longer than one cycle");
  assert property (@(posedge clk) disable iff (rst) done |-> (result < m))
    else $error("mulmod result not reduced");

endmodule

[rtl/mmpv_datapath.sv]
// matrix and vector stores, multiply-accumulate unit and output register
// depends on mmpv_pkg, mmpv_ram, mmpv_mulmod
module mmpv_datapath #(
  parameter int MAX_DIM = 8,
  parameter int IDX_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
  parameter int ADDR_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mmpv_pkg::cmd_t                cmd,
  output mmpv_pkg::status_t             status,
  input  logic [ADDR_W-1:0]             addr_ij,
  input  logic [ADDR_W-1:0]             addr_ik,
  input  logic [ADDR_W-1:0]             addr_kj,
  input  logic [IDX_W-1:0]              vec_k,
  input  logic [mmpv_pkg::VALUE_W-1:0]  value,
  input  logic [mmpv_pkg::VALUE_W-1:0]  m,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [mmpv_pkg::INDEX_W-1:0]  out_index,
  output logic [mmpv_pkg::VALUE_W-1:0]  out_element,
  output logic                          out_last
);
  import mmpv_pkg::*;

  logic [VALUE_W-1:0] base_rd, vec_rd, p0_rd, p1_rd, q_rd, p_wdata;
  logic [VALUE_W-1:0] acc, mul_a, mul_b, mul_res;
  logic               p_we, mul_done;

  assign p_we    = cmd.p_init | cmd.p_copy;
  assign p_wdata = cmd.p_init ? VALUE_W'(cmd.p_init_one) : q_rd;

  mmpv_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_DIM * MAX_DIM), .AW(ADDR_W)) u_base (
    .clk(clk), .we(cmd.ld_base), .waddr(addr_ij), .wdata(value),
    .raddr(addr_ik), .rdata(base_rd));

  mmpv_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_DIM), .AW(IDX_W)) u_vec (
    .clk(clk), .we(cmd.ld_vec), .waddr(vec_k), .wdata(value),
    .raddr(vec_k), .rdata(vec_rd));

  // power matrix kept twice so row and column operands read together
  mmpv_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_DIM * MAX_DIM), .AW(ADDR_W)) u_pow0 (
    .clk(clk), .we(p_we), .waddr(addr_ij), .wdata(p_wdata),
    .raddr(addr_ik), .rdata(p0_rd));

  mmpv_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_DIM * MAX_DIM), .AW(ADDR_W)) u_pow1 (
    .clk(clk), .we(p_we), .waddr(addr_ij), .wdata(p_wdata),
    .raddr(addr_kj), .rdata(p1_rd));

  mmpv_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_DIM * MAX_DIM), .AW(ADDR_W)) u_prod (
    .clk(clk), .we(cmd.q_we), .waddr(addr_ij), .wdata(acc),
    .raddr(addr_ij), .rdata(q_rd));

  // a operand may be unreduced, only its bits are scanned
  always_comb begin
    unique case (cmd.a_sel)
      ASEL_BASE:  mul_a = base_rd;
      ASEL_POWER: mul_a = p0_rd;
      ASEL_VEC:   mul_a = vec_rd;
      default:    mul_a = '0;
    endcase
    mul_b = cmd.b_row ? p0_rd : p1_rd;
  end

  mmpv_mulmod u_mul (
    .clk(clk), .rst(rst), .start(cmd.mul_start), .a(mul_a), .b(mul_b),
    .acc(acc), .m(m), .done(mul_done), .result(mul_res));

  always_ff @(posedge clk) begin
    if (cmd.acc_clear) begin
      acc <= '0;
    end else if (mul_done) begin
      acc <= mul_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid   <= 1'b1;
      out_index   <= cmd.out_index;
      out_element <= acc;
      out_last    <= cmd.out_last;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign status.mul_done = mul_done;
  assign status.out_busy = out_valid;

  assert property (@(posedge clk) disable iff (rst) cmd.out_load |-> !out_valid)
    else $error("result loaded over a pending transfer");

endmodule

[rtl/mmpv_ctrl.sv]
// sequencer for loads, identity fill, square-and-multiply and vector product
// depends on mmpv_pkg
module mmpv_ctrl #(
  parameter int MAX_DIM = 8,
  parameter int IDX_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
  parameter int ADDR_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  action,
  input  logic [mmpv_pkg::INDEX_W-1:0] row,
  input  logic [mmpv_pkg::INDEX_W-1:0] col,
  input  logic [mmpv_pkg::EXP_W-1:0]  exponent,
  input  logic [IDX_W-1:0]            n_last,
  input  logic                        m_one,
  input  mmpv_pkg::status_t           status,
  output mmpv_pkg::cmd_t              cmd,
  output logic [ADDR_W-1:0]           addr_ij,
  output logic [ADDR_W-1:0]           addr_ik,
  output logic [ADDR_W-1:0]           addr_kj,
  output logic [IDX_W-1:0]            vec_k
);
  import mmpv_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_INIT  = 4'd1;
  localparam logic [3:0] S_BIT   = 4'd2;
  localparam logic [3:0] S_MRD   = 4'd3;
  localparam logic [3:0] S_MGO   = 4'd4;
  localparam logic [3:0] S_MWAIT = 4'd5;
  localparam logic [3:0] S_MWR   = 4'd6;
  localparam logic [3:0] S_CRD   = 4'd7;
  localparam logic [3:0] S_CWR   = 4'd8;
  localparam logic [3:0] S_ORD   = 4'd9;
  localparam logic [3:0] S_OGO   = 4'd10;
  localparam logic [3:0] S_OWAIT = 4'd11;
  localparam logic [3:0] S_OEMIT = 4'd12;

  localparam logic OP_BASE   = 1'b0;
  localparam logic OP_SQUARE = 1'b1;

  localparam int BIT_W = $clog2(EXP_W);

  logic [3:0]       state;
  logic [IDX_W-1:0] i, j, k;
  logic [EXP_W-1:0] exp_reg;
  logic [BIT_W-1:0] bitn;
  logic             started, op, in_fire, row_ok, col_ok, ij_end;

  function automatic logic [ADDR_W-1:0] flat(input logic [IDX_W-1:0] r,
                                             input logic [IDX_W-1:0] c);
    flat = ADDR_W'(ADDR_W'(r) * ADDR_W'(MAX_DIM) + ADDR_W'(c));
  endfunction

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid & in_ready;
  assign row_ok   = ({1'b0, row} < (INDEX_W + 1)'(MAX_DIM));
  assign col_ok   = ({1'b0, col} < (INDEX_W + 1)'(MAX_DIM));
  assign ij_end   = (i == n_last) && (j == n_last);

  always_comb begin
    addr_ik = flat(i, k);
    addr_kj = flat(k, j);
    if (state == S_IDLE) begin
      addr_ij = flat(row[IDX_W-1:0], col[IDX_W-1:0]);
      vec_k   = row[IDX_W-1:0];
    end else begin
      addr_ij = flat(i, j);
      vec_k   = k;
    end
  end

  always_comb begin
    logic out_phase;
    out_phase          = (state == S_ORD) || (state == S_OGO) || (state == S_OWAIT);
    cmd.ld_base        = in_fire && (action == ACT_MATRIX) && row_ok && col_ok;
    cmd.ld_vec         = in_fire && (action == ACT_VECTOR) && row_ok;
    cmd.p_init         = (state == S_INIT);
    cmd.p_init_one     = (i == j) && !m_one;
    cmd.p_copy         = (state == S_CWR);
    cmd.q_we           = (state == S_MWR);
    cmd.mul_start      = (state == S_MGO) || (state == S_OGO);
    cmd.out_load       = (state == S_OEMIT) && !status.out_busy;
    cmd.acc_clear      = (state == S_BIT) || (state == S_MWR) || (state == S_CWR) ||
                         cmd.out_load;
    cmd.a_sel          = out_phase ? ASEL_VEC : ((op == OP_SQUARE) ? ASEL_POWER : ASEL_BASE);
    cmd.b_row          = out_phase;
    cmd.out_last       = (i == n_last);
    cmd.out_index      = INDEX_W'(i);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      i       <= '0;
      j       <= '0;
      k       <= '0;
      bitn    <= '0;
      started <= 1'b0;
      op      <= OP_BASE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_fire && (action == ACT_RUN)) begin
            exp_reg <= exponent;
            i       <= '0;
            j       <= '0;
            k       <= '0;
            state   <= S_INIT;
          end
        end
        S_INIT: begin
          if (j == n_last) begin
            j <= '0;
            if (i == n_last) begin
              i       <= '0;
              bitn    <= BIT_W'(EXP_W - 1);
              started <= 1'b0;
              state   <= S_BIT;
            end else begin
              i <= i + 1'b1;
            end
          end else begin
            j <= j + 1'b1;
          end
        end
        S_BIT: begin
          if (started) begin
            op    <= OP_SQUARE;
            state <= S_MRD;
          end else if (exp_reg[bitn]) begin
            op    <= OP_BASE;
            state <= S_MRD;
          end else if (bitn == '0) begin
            state <= S_ORD;
          end else begin
            bitn <= bitn - 1'b1;
          end
        end
        S_MRD:   state <= S_MGO;
        S_MGO:   state <= S_MWAIT;
        S_MWAIT: begin
          if (status.mul_done) begin
            if (k == n_last) begin
              k     <= '0;
              state <= S_MWR;
            end else begin
              k     <= k + 1'b1;
              state <= S_MRD;
            end
          end
        end
        S_MWR: begin
          if (ij_end) begin
            i     <= '0;
            j     <= '0;
            state <= S_CRD;
          end else begin
            state <= S_MRD;
            if (j == n_last) begin
              j <= '0;
              i <= i + 1'b1;
            end else begin
              j <= j + 1'b1;
            end
          end
        end
        S_CRD: state <= S_CWR;
        S_CWR: begin
          if (ij_end) begin
            i <= '0;
            j <= '0;
            if ((op == OP_SQUARE) && exp_reg[bitn]) begin
              op    <= OP_BASE;
              state <= S_MRD;
            end else begin
              if (op == OP_BASE) begin
                started <= 1'b1;
              end
              if (bitn == '0) begin
                state <= S_ORD;
              end else begin
                bitn  <= bitn - 1'b1;
                state <= S_BIT;
              end
            end
          end else begin
            state <= S_CRD;
            if (j == n_last) begin
              j <= '0;
              i <= i + 1'b1;
            end else begin
              j <= j + 1'b1;
            end
          end
        end
        S_ORD:   state <= S_OGO;
        S_OGO:   state <= S_OWAIT;
        S_OWAIT: begin
          if (status.mul_done) begin
            if (k == n_last) begin
              k     <= '0;
              state <= S_OEMIT;
            end else begin
              k     <= k + 1'b1;
              state <= S_ORD;
            end
          end
        end
        S_OEMIT: begin
          if (!status.out_busy) begin
            if (i == n_last) begin
              i     <= '0;
              state <= S_IDLE;
            end else begin
              i     <= i + 1'b1;
              state <= S_ORD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
                   (in_fire && (action == ACT_RUN)) |=> (state == S_INIT))
    else $error("run transfer did not start the identity fill");
  assert property (@(posedge clk) disable iff (rst)
                   cmd.mul_start |=> !cmd.mul_start)
    else $error("back to back multiplier starts");

endmodule

[rtl/modular_matrix_power_vector.sv]
// Loads a matrix and a vector entry by entry; a run item raises the matrix to
// its exponent mod the modulus by square-and-multiply and streams out P*v.
// A run does at most twice the exponent width squarings and base multiplies in
// all, and each of their multiply-accumulates goes through the single
// bit-serial modular multiplier; no new item is accepted while a run is busy.
// depends on mmpv_pkg, mmpv_ctrl, mmpv_datapath
module modular_matrix_power_vector #(
  parameter int MAX_DIM = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [103:0] s_tdata,   // row[3:0], col[7:4], value[38:8], exponent[101:39]
  input  logic [1:0]   s_tuser,   // action[1:0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [39:0]  m_tdata,   // index[3:0], element[34:4]
  output logic         m_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import mmpv_pkg::*;

  localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int ADDR_W = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;

  logic [VALUE_W-1:0] modulus, m_eff, out_element;
  logic [DIM_W-1:0]   dim;
  logic [IDX_W-1:0]   n_last, vec_k;
  logic [ADDR_W-1:0]  addr_ij, addr_ik, addr_kj;
  logic [INDEX_W-1:0] out_index;
  cmd_t               cmd;
  status_t            status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= RESET_MODULUS;
      dim     <= RESET_DIM;
    end else if (cfg_valid) begin
      if (cfg_index == REG_MODULUS) begin
        modulus <= cfg_data[VALUE_W-1:0];
      end else if (cfg_index == REG_DIM) begin
        dim <= cfg_data[DIM_W-1:0];
      end
    end
  end

  // zero modulus acts as one, dim clamped to 1..MAX_DIM
  assign m_eff = (modulus == '0) ? VALUE_W'(1) : modulus;
  always_comb begin
    if (dim == '0) begin
      n_last = '0;
    end else if (dim > DIM_W'(MAX_DIM)) begin
      n_last = IDX_W'(MAX_DIM - 1);
    end else begin
      n_last = IDX_W'(dim - 1'b1);
    end
  end

  mmpv_ctrl #(.MAX_DIM(MAX_DIM), .IDX_W(IDX_W), .ADDR_W(ADDR_W)) u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .in_ready(s_tready),
    .action(s_tuser), .row(s_tdata[3:0]), .col(s_tdata[7:4]),
    .exponent(s_tdata[101:39]), .n_last(n_last), .m_one(m_eff == VALUE_W'(1)),
    .status(status), .cmd(cmd), .addr_ij(addr_ij), .addr_ik(addr_ik),
    .addr_kj(addr_kj), .vec_k(vec_k));

  mmpv_datapath #(.MAX_DIM(MAX_DIM), .IDX_W(IDX_W), .ADDR_W(ADDR_W)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status), .addr_ij(addr_ij),
    .addr_ik(addr_ik), .addr_kj(addr_kj), .vec_k(vec_k),
    .value(s_tdata[38:8]), .m(m_eff), .out_ready(m_tready),
    .out_valid(m_tvalid), .out_index(out_index), .out_element(out_element),
    .out_last(m_tlast));

  assign m_tdata = {5'b0, out_element, out_index};

endmodule
